// ----- sv/c3sf_pkg.sv -----
// shared types and constants for the 3x3 saturating image filter
// no dependencies; imported by every module of the block but the ram
`default_nettype none

package c3sf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WID_W       = $clog2(MAX_WIDTH + 1);
  localparam int CFG_W       = 11;
  localparam int ROW_W       = 11;
  localparam int PIX_W       = 8;
  localparam int SUM_W       = PIX_W + 3;
  localparam int IDX_W       = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] DEF_WIDTH  = CFG_W'(800);
  localparam logic [CFG_W-1:0] DEF_HEIGHT = CFG_W'(800);
  localparam logic [CFG_W-1:0] MIN_DIM    = CFG_W'(2);
  localparam logic [PIX_W-1:0] SAT_MAX    = PIX_W'(255);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // one classified slot on its way from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic             produce;
    logic             last;
    logic             clr_top;
    logic             clr_bottom;
    logic             clr_left;
    logic             clr_right;
  } item_t;

endpackage

`default_nettype wire

// ----- sv/c3sf_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module c3sf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/c3sf_front.sv -----
// front part: size registers, slot counters and classification of each request
// depends on c3sf_pkg
`default_nettype none

module c3sf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [c3sf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [c3sf_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        src_valid,
  input  logic                        op,
  input  logic [c3sf_pkg::PIX_W-1:0]  pixel,
  input  logic                        full,
  output logic                        push,
  output c3sf_pkg::item_t             item,
  output logic                        restart
);

  import c3sf_pkg::*;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] ocol;
  logic [ROW_W-1:0] orow;

  logic [WID_W-1:0] eff_w;
  logic [CFG_W-1:0] eff_h;
  logic [COL_W-1:0] c;
  logic [WID_W-1:0] col_inc;
  logic [WID_W-1:0] ocol_inc;
  logic             expected;
  logic             is_flush;
  logic             produce;
  logic             last;
  logic             cfg_hit;

  always_comb begin
    if (32'(width_reg) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else if (width_reg < MIN_DIM) begin
      eff_w = WID_W'(MIN_DIM);
    end else begin
      eff_w = WID_W'(width_reg);
    end
    if (32'(height_reg) > MAX_HEIGHT) begin
      eff_h = CFG_W'(MAX_HEIGHT);
    end else if (height_reg < MIN_DIM) begin
      eff_h = MIN_DIM;
    end else begin
      eff_h = height_reg;
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(cfg_index))
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: cfg_hit = cfg_we;
      default:                           cfg_hit = 1'b0;
    endcase
  end

  assign restart  = cfg_hit;
  assign expected = ROW_W'(row) < ROW_W'(eff_h);
  assign is_flush = op_t'(op) == OP_FLUSH;
  assign push     = src_valid && !full && !(expected && is_flush);

  assign c        = (WID_W'(col) >= eff_w) ? '0 : col;
  assign col_inc  = WID_W'(c) + WID_W'(1);
  assign ocol_inc = WID_W'(ocol) + WID_W'(1);
  assign produce  = !((row == '0) || ((row == ROW_W'(1)) && (c == '0)));
  assign last     = produce && (ocol_inc == eff_w) && (orow == ROW_W'(eff_h - CFG_W'(1)));

  always_comb begin
    item.pixel      = expected ? pixel : '0;
    item.col        = c;
    item.produce    = produce;
    item.last       = last;
    item.clr_top    = orow == '0;
    item.clr_bottom = orow == ROW_W'(eff_h - CFG_W'(1));
    item.clr_left   = ocol == '0;
    item.clr_right  = ocol_inc == eff_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= DEF_WIDTH;
      height_reg <= DEF_HEIGHT;
      col        <= '0;
      row        <= '0;
      ocol       <= '0;
      orow       <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
        default: begin
        end
      endcase
      col  <= '0;
      row  <= '0;
      ocol <= '0;
      orow <= '0;
    end else if (push) begin
      if (last) begin
        col  <= '0;
        row  <= '0;
        ocol <= '0;
        orow <= '0;
      end else begin
        if (col_inc >= eff_w) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= COL_W'(col_inc);
        end
        if (produce) begin
          if (ocol_inc >= eff_w) begin
            ocol <= '0;
            orow <= orow + ROW_W'(1);
          end else begin
            ocol <= COL_W'(ocol_inc);
          end
        end
      end
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    WID_W'(col) < eff_w)
    else $error("column counter beyond row width");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    push && item.last |=> (col == '0) && (row == '0) && (ocol == '0) && (orow == '0))
    else $error("counters not cleared after final pixel of frame");

endmodule

`default_nettype wire

// ----- sv/c3sf_queue.sv -----
// short queue of classified slots between front and back
// depends on c3sf_pkg
`default_nettype none

module c3sf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  c3sf_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output c3sf_pkg::item_t head_item
);

  import c3sf_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

`default_nettype wire

// ----- sv/c3sf_back.sv -----
// back part: line buffer read-modify-write, 3x3 window, weighted sum and result register
// depends on c3sf_pkg and c3sf_ram
`default_nettype none

module c3sf_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic                       head_valid,
  input  c3sf_pkg::item_t            head_item,
  output logic                       pop,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [c3sf_pkg::PIX_W-1:0] out_pixel,
  output logic                       out_last
);

  import c3sf_pkg::*;

  logic             a_valid;
  item_t            a_item;
  logic             a_adv;
  logic [2*PIX_W-1:0] rd;
  logic [PIX_W-1:0] rd_mid;
  logic [PIX_W-1:0] rd_top;

  // window columns zero and one of each row; column two comes from the line ram and the current pixel
  logic [PIX_W-1:0] top_c1, top_c2;
  logic [PIX_W-1:0] mid_c1, mid_c2;
  logic [PIX_W-1:0] bot_c1, bot_c2;

  logic [PIX_W-1:0] tl, tr, ml, mr, bl, br;
  logic [SUM_W-1:0] sum;
  logic [PIX_W-1:0] sat;
  logic             o_valid;

  // each entry holds the row above and the row two above at that column
  c3sf_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (a_adv),
    .waddr (a_item.col),
    .wdata ({a_item.pixel, rd_mid}),
    .re    (pop),
    .raddr (head_item.col),
    .rdata (rd)
  );

  assign rd_mid = rd[2*PIX_W-1:PIX_W];
  assign rd_top = rd[PIX_W-1:0];

  assign a_adv = a_valid && (!a_item.produce || !o_valid || !res_stall);
  assign pop   = head_valid && (!a_valid || a_adv);

  always_comb begin
    tl  = (a_item.clr_top || a_item.clr_left)     ? '0 : top_c1;
    tr  = (a_item.clr_top || a_item.clr_right)    ? '0 : rd_top;
    ml  = a_item.clr_left                         ? '0 : mid_c1;
    mr  = a_item.clr_right                        ? '0 : rd_mid;
    bl  = (a_item.clr_bottom || a_item.clr_left)  ? '0 : bot_c1;
    br  = (a_item.clr_bottom || a_item.clr_right) ? '0 : a_item.pixel;
    sum = SUM_W'(tl) + SUM_W'(tr) + SUM_W'(bl) + SUM_W'(br)
        + ((SUM_W'(ml) + SUM_W'(mr)) << 1);
    sat = (sum > SUM_W'(SAT_MAX)) ? SAT_MAX : PIX_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pop) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_item <= head_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart || (a_adv && a_item.last)) begin
      top_c1 <= '0;
      top_c2 <= '0;
      mid_c1 <= '0;
      mid_c2 <= '0;
      bot_c1 <= '0;
      bot_c2 <= '0;
    end else if (a_adv) begin
      top_c1 <= top_c2;
      top_c2 <= rd_top;
      mid_c1 <= mid_c2;
      mid_c2 <= rd_mid;
      bot_c1 <= bot_c2;
      bot_c2 <= a_item.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (a_adv && a_item.produce) begin
      o_valid <= 1'b1;
    end else if (!res_stall) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_item.produce) begin
      out_pixel <= sat;
      out_last  <= a_item.last;
    end
  end

  assign res_valid = o_valid;

  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    a_adv && a_item.last |=> (top_c2 == '0) && (mid_c2 == '0) && (bot_c2 == '0)
                             && (top_c1 == '0) && (mid_c1 == '0) && (bot_c1 == '0))
    else $error("window not cleared after final pixel of frame");

endmodule

`default_nettype wire

// ----- sv/conv3x3_saturating_filter.sv -----
// top level of the 3x3 saturating image filter
// depends on c3sf_pkg, c3sf_front, c3sf_queue and c3sf_back
//
// Streams 8-bit grayscale pixels in raster order and returns one filtered pixel per input
// pixel, one row and one column behind the input; after a frame's pixels, width+1 flush
// requests push out the rest and the final result carries out_last. A request is taken every
// clock while the four-entry queue has room; each slot is classified in the front as it is
// taken, then passes through the queue and the line buffer read stage before the result
// register loads. The line buffers are one ram with a read and a write port, which takes a
// read and a write each clock. Size writes restart the frame; they are to be made only while
// the block is idle, which the block itself does not enforce.
// The line ram has no reset and needs none.
`default_nettype none

module conv3x3_saturating_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [c3sf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [c3sf_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        src_valid,
  output logic                        src_stall,
  input  logic                        op,
  input  logic [c3sf_pkg::PIX_W-1:0]  pixel,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [c3sf_pkg::PIX_W-1:0]  out_pixel,
  output logic                        out_last
);

  import c3sf_pkg::*;

  logic  full;
  logic  push;
  item_t push_item;
  logic  restart;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  assign src_stall = full;

  c3sf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .src_valid (src_valid),
    .op        (op),
    .pixel     (pixel),
    .full      (full),
    .push      (push),
    .item      (push_item),
    .restart   (restart)
  );

  c3sf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  c3sf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_pixel  (out_pixel),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire
